/* hdl/lav_pkg.sv */
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and constants of the look-at view matrix core: request and
// result payloads, the queued job format and the matrix handed to the emitter.
// ----------------------------------------------------------------------------
package lav_pkg;

    // default number of fraction bits of the fixed-point format
    localparam int LAV_FRAC_BITS = 16;

    // depth of the job queue between front and back
    localparam int LAV_Q_DEPTH = 2;

    // result group codes
    typedef enum logic [1:0] {
        GRP_X = 2'd0,
        GRP_Y = 2'd1,
        GRP_Z = 2'd2,
        GRP_C = 2'd3
    } t_lav_grp;

    // one request: eye, target and up, signed fixed point
    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } t_lav_req;

    // one result group
    typedef struct packed {
        logic        [1:0]  group_index;
        logic signed [31:0] elem0;
        logic signed [31:0] elem1;
        logic signed [31:0] elem2;
        logic signed [31:0] elem3;
        logic               last_group;
        logic               degenerate;
    } t_lav_rsp;

    // classified job as queued for the back end
    typedef struct packed {
        logic signed [2:0][31:0] eye;
        logic signed [2:0][31:0] up;
        logic signed [2:0][32:0] dir;   // eye minus target, exact
        logic                    zdeg;  // eye equals target
    } t_lav_job;

    // finished matrix rows x, y, z: three axis elements and translation
    typedef struct packed {
        logic [2:0][3:0][31:0] rows;
        logic                  deg;
    } t_lav_mat;

endpackage

/* hdl/lav_front.sv */
// ----------------------------------------------------------------------------
// lav_front
// Request stage: takes a request, forms the view direction eye minus target
// and flags the case where eye and target coincide.
// ----------------------------------------------------------------------------
module lav_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  lav_pkg::t_lav_req   i_req,
    input  logic                i_q_full,
    output logic                o_push,
    output lav_pkg::t_lav_job   o_job
);
    import lav_pkg::*;

    logic     r_valid;
    t_lav_job r_job;
    t_lav_job n_job;
    logic     accept;

    // classify the request
    always_comb begin
        n_job = '0;
        n_job.eye[0] = i_req.eye_x;
        n_job.eye[1] = i_req.eye_y;
        n_job.eye[2] = i_req.eye_z;
        n_job.up[0]  = i_req.up_x;
        n_job.up[1]  = i_req.up_y;
        n_job.up[2]  = i_req.up_z;
        n_job.dir[0] = {i_req.eye_x[31], i_req.eye_x} - {i_req.target_x[31], i_req.target_x};
        n_job.dir[1] = {i_req.eye_y[31], i_req.eye_y} - {i_req.target_y[31], i_req.target_y};
        n_job.dir[2] = {i_req.eye_z[31], i_req.eye_z} - {i_req.target_z[31], i_req.target_z};
        n_job.zdeg   = (i_req.eye_x == i_req.target_x) && (i_req.eye_y == i_req.target_y)
                       && (i_req.eye_z == i_req.target_z);
    end

    assign busy   = r_valid && i_q_full;
    assign accept = start && !busy;
    assign o_push = r_valid && !i_q_full;
    assign o_job  = r_job;

    // holding register in front of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

/* hdl/lav_queue.sv */
// ----------------------------------------------------------------------------
// lav_queue
// Short job queue that lets the request stage and the back end stall
// independently.
// ----------------------------------------------------------------------------
module lav_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lav_pkg::t_lav_job   i_job,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output lav_pkg::t_lav_job   o_job
);
    import lav_pkg::*;

    localparam int IW = (LAV_Q_DEPTH > 1) ? $clog2(LAV_Q_DEPTH) : 1;
    localparam int CW = $clog2(LAV_Q_DEPTH + 1);

    t_lav_job        r_mem [LAV_Q_DEPTH];
    logic [IW-1:0]   r_wp;
    logic [IW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(LAV_Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == IW'(LAV_Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == IW'(LAV_Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    // no write into a full queue, no read from an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("queue read while empty");

endmodule

/* hdl/lav_back.sv */
// ----------------------------------------------------------------------------
// lav_back
// Back end sequencer: normalizes the view direction, crosses with up,
// normalizes again, builds the y axis and the translation terms. One shared
// multiply-accumulate pipe, a bit-pair square root and a restoring divider.
// ----------------------------------------------------------------------------
module lav_back #(
    parameter int FRAC_BITS = lav_pkg::LAV_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  lav_pkg::t_lav_job   i_job,
    output logic                o_job_pop,
    input  logic                i_mat_ready,
    output logic                o_mat_valid,
    output lav_pkg::t_lav_mat   o_mat
);
    import lav_pkg::*;

    localparam int MW       = 33 + FRAC_BITS;   // magnitude before normalizing
    localparam int AW       = FRAC_BITS + 3;    // stored axis element
    localparam int QW       = FRAC_BITS + 1;    // quotient bits
    localparam int NW       = 31 + FRAC_BITS;   // dividend bits
    localparam int OW       = 33;               // multiplier operand
    localparam int PW       = 2 * OW;           // product and accumulator
    localparam int SQW      = 62;               // sum of squares
    localparam int RTW      = SQW / 2;          // root bits
    localparam int SRW      = RTW + 2;          // root remainder
    localparam int SQ_STEPS = RTW;
    localparam int CW       = $clog2(((QW > SQ_STEPS) ? QW : SQ_STEPS) + 1);
    localparam int NORM_HI  = 30;
    localparam int NORM_LO  = 29;
    localparam int AX_X     = 0;
    localparam int AX_Y     = 1;
    localparam int AX_Z     = 2;

    localparam logic signed [PW-1:0] HALF   = PW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] SAT_HI = PW'(1) <<< 31;
    localparam logic signed [PW-1:0] SAT_LO = -(SAT_HI - PW'(1));
    localparam logic        [QW-1:0] Q_ONE  = QW'(1) << FRAC_BITS;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_NSHIFT = 6'b000010,
        S_MAC    = 6'b000100,
        S_SQRT   = 6'b001000,
        S_DIV    = 6'b010000,
        S_FIN    = 6'b100000
    } t_lav_state;

    typedef enum logic [1:0] {
        PH_SQ  = 2'd0,
        PH_CR1 = 2'd1,
        PH_CR2 = 2'd2,
        PH_DOT = 2'd3
    } t_lav_phase;

    t_lav_state r_state;
    t_lav_phase r_ph;
    logic       r_pass;
    logic       r_deg;

    logic signed [31:0]   r_eye [3];
    logic signed [31:0]   r_up  [3];
    logic        [MW-1:0] r_nmag [3];
    logic                 r_nneg [3];
    logic signed [AW-1:0] r_ax [3][3];
    logic signed [31:0]   r_t [3];

    logic [CW-1:0]  r_cnt;
    logic [1:0]     r_di;
    logic [SQW-1:0] r_sq;
    logic [RTW-1:0] r_root;
    logic [SRW-1:0] r_srem;
    logic [31:0]    r_drem;
    logic [QW-1:0]  r_dlow;
    logic [QW-1:0]  r_q;

    logic                 r_missue;
    logic [1:0]           r_mj;
    logic [1:0]           r_mt;
    logic                 r_pv;
    logic signed [PW-1:0] r_prod;
    logic                 r_pneg;
    logic                 r_pfirst;
    logic                 r_plast;
    logic [1:0]           r_pj;
    logic signed [PW-1:0] r_acc;
    logic                 r_rv;
    logic signed [PW-1:0] r_raw;
    logic [1:0]           r_rj;

    logic [MW-1:0]        max_mag;
    logic signed [OW-1:0] op_a;
    logic signed [OW-1:0] op_b;
    logic                 op_neg;
    logic [1:0]           tmax;
    logic [1:0]           jmax;
    logic [1:0]           i1;
    logic [1:0]           i2;
    logic signed [PW-1:0] acc_sum;
    logic signed [PW-1:0] raw_mag;
    logic signed [PW-1:0] rs_sum;
    logic signed [PW-1:0] rs;
    logic signed [31:0]   dot_sat;
    logic [SRW+1:0]       sq_trial_rem;
    logic [SRW+1:0]       sq_trial;
    logic                 sq_ge;
    logic [32:0]          dv_trial;
    logic                 dv_ge;
    logic [QW-1:0]        n_q;
    logic [NW-1:0]        dv_num;
    logic                 div_last;
    int                   pax;

    // largest magnitude of the vector being normalized
    always_comb begin
        max_mag = r_nmag[0];
        if (r_nmag[1] > max_mag) begin
            max_mag = r_nmag[1];
        end
        if (r_nmag[2] > max_mag) begin
            max_mag = r_nmag[2];
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        unique case (r_mj)
            2'd0: begin
                i1 = 2'd1;
                i2 = 2'd2;
            end
            2'd1: begin
                i1 = 2'd2;
                i2 = 2'd0;
            end
            default: begin
                i1 = 2'd0;
                i2 = 2'd1;
            end
        endcase
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        tmax   = 2'd2;
        jmax   = 2'd2;
        unique case (r_ph)
            PH_SQ: begin
                jmax = 2'd0;
                op_a = OW'({1'b0, r_nmag[r_mt][NORM_HI-1:0]});
                op_b = op_a;
            end
            PH_CR1: begin
                tmax = 2'd1;
                if (r_mt == 2'd0) begin
                    op_a = OW'(r_up[i1]);
                    op_b = OW'(r_ax[AX_Z][i2]);
                end else begin
                    op_a   = OW'(r_up[i2]);
                    op_b   = OW'(r_ax[AX_Z][i1]);
                    op_neg = 1'b1;
                end
            end
            PH_CR2: begin
                tmax = 2'd1;
                if (r_mt == 2'd0) begin
                    op_a = OW'(r_ax[AX_Z][i1]);
                    op_b = OW'(r_ax[AX_X][i2]);
                end else begin
                    op_a   = OW'(r_ax[AX_Z][i2]);
                    op_b   = OW'(r_ax[AX_X][i1]);
                    op_neg = 1'b1;
                end
            end
            default: begin
                op_a = OW'(r_ax[r_mj][r_mt]);
                op_b = OW'(r_eye[r_mt]);
            end
        endcase
    end

    // accumulate and post-processing arithmetic
    always_comb begin
        acc_sum = (r_pfirst ? '0 : r_acc) + (r_pneg ? -r_prod : r_prod);
        raw_mag = r_raw[PW-1] ? -r_raw : r_raw;
        // round half away from zero, then drop the fraction bits
        rs_sum  = r_raw + HALF - PW'(r_raw[PW-1]);
        rs      = rs_sum >>> FRAC_BITS;
        if (rs > SAT_HI) begin
            dot_sat = 32'sh8000_0000;
        end else if (rs < SAT_LO) begin
            dot_sat = 32'sh7fff_ffff;
        end else begin
            dot_sat = 32'(-rs);
        end
    end

    // square root and divider steps
    always_comb begin
        sq_trial_rem = {r_srem, r_sq[SQW-1 -: 2]};
        sq_trial     = (SRW + 2)'({r_root, 2'b01});
        sq_ge        = (sq_trial_rem >= sq_trial);
        dv_num       = ({r_nmag[r_di][NORM_HI-1:0], {FRAC_BITS{1'b0}}} + NW'(r_root >> 1));
        dv_trial     = {r_drem, r_dlow[QW-1]};
        dv_ge        = (dv_trial >= {2'b00, r_root});
        n_q          = {r_q[QW-2:0], dv_ge};
        div_last     = (r_state == S_DIV) && (r_cnt == CW'(QW));
        pax          = r_pass ? AX_X : AX_Z;
    end

    assign o_job_pop   = (r_state == S_IDLE) && i_job_valid;
    assign o_mat_valid = (r_state == S_FIN);

    // matrix rows handed to the emitter
    always_comb begin
        o_mat     = '0;
        o_mat.deg = r_deg;
        for (int g = 0; g < 3; g++) begin
            for (int k = 0; k < 3; k++) begin
                o_mat.rows[g][k] = 32'(r_ax[g][k]);
            end
            o_mat.rows[g][3] = r_t[g];
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_missue <= 1'b0;
            r_pv     <= 1'b0;
            r_rv     <= 1'b0;
        end else begin
            r_pv <= 1'b0;
            r_rv <= 1'b0;

            // product issue
            if (r_state == S_MAC && r_missue) begin
                r_pv     <= 1'b1;
                r_prod   <= op_a * op_b;
                r_pneg   <= op_neg;
                r_pfirst <= (r_mt == 2'd0);
                r_plast  <= (r_mt == tmax);
                r_pj     <= r_mj;
                if (r_mt == tmax) begin
                    r_mt <= 2'd0;
                    if (r_mj == jmax) begin
                        r_missue <= 1'b0;
                    end else begin
                        r_mj <= r_mj + 2'd1;
                    end
                end else begin
                    r_mt <= r_mt + 2'd1;
                end
            end

            // accumulate
            if (r_pv) begin
                r_acc <= acc_sum;
                if (r_plast) begin
                    r_rv  <= 1'b1;
                    r_raw <= acc_sum;
                    r_rj  <= r_pj;
                end
            end

            // write back a finished sum
            if (r_rv) begin
                case (r_ph)
                    PH_SQ: r_sq <= r_raw[SQW-1:0];
                    PH_CR1: begin
                        r_nmag[r_rj] <= raw_mag[MW-1:0];
                        r_nneg[r_rj] <= r_raw[PW-1];
                    end
                    PH_CR2: r_ax[AX_Y][r_rj] <= rs[AW-1:0];
                    default: r_t[r_rj] <= dot_sat;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        for (int k = 0; k < 3; k++) begin
                            r_eye[k]  <= i_job.eye[k];
                            r_up[k]   <= i_job.up[k];
                            r_nmag[k] <= MW'(i_job.dir[k][32] ? 33'(-i_job.dir[k])
                                                              : i_job.dir[k]);
                            r_nneg[k] <= i_job.dir[k][32];
                        end
                        r_deg  <= i_job.zdeg;
                        r_pass <= 1'b0;
                        if (i_job.zdeg) begin
                            // coincident eye and target: all-zero rows
                            for (int g = 0; g < 3; g++) begin
                                for (int k = 0; k < 3; k++) begin
                                    r_ax[g][k] <= '0;
                                end
                                r_t[g] <= '0;
                            end
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_NSHIFT;
                        end
                    end
                end
                S_NSHIFT: begin
                    if (max_mag == '0) begin
                        // zero-length vector
                        r_deg <= 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            r_ax[pax][k] <= '0;
                        end
                        r_ph     <= r_pass ? PH_CR2 : PH_CR1;
                        r_missue <= 1'b1;
                        r_mj     <= 2'd0;
                        r_mt     <= 2'd0;
                        r_state  <= S_MAC;
                    end else if (|max_mag[MW-1:NORM_HI]) begin
                        for (int k = 0; k < 3; k++) begin
                            r_nmag[k] <= r_nmag[k] >> 1;
                        end
                    end else if (!max_mag[NORM_LO]) begin
                        for (int k = 0; k < 3; k++) begin
                            r_nmag[k] <= r_nmag[k] << 1;
                        end
                    end else begin
                        r_ph     <= PH_SQ;
                        r_missue <= 1'b1;
                        r_mj     <= 2'd0;
                        r_mt     <= 2'd0;
                        r_state  <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_rv && r_rj == jmax) begin
                        unique case (r_ph)
                            PH_SQ: begin
                                r_cnt   <= '0;
                                r_root  <= '0;
                                r_srem  <= '0;
                                r_state <= S_SQRT;
                            end
                            PH_CR1: begin
                                r_pass  <= 1'b1;
                                r_state <= S_NSHIFT;
                            end
                            PH_CR2: begin
                                r_ph     <= PH_DOT;
                                r_missue <= 1'b1;
                                r_mj     <= 2'd0;
                                r_mt     <= 2'd0;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_SQRT: begin
                    // one root bit per cycle
                    r_sq   <= r_sq << 2;
                    r_root <= {r_root[RTW-2:0], sq_ge};
                    r_srem <= sq_ge ? SRW'(sq_trial_rem - sq_trial) : SRW'(sq_trial_rem);
                    if (r_cnt == CW'(SQ_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_di    <= 2'd0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_drem <= 32'(dv_num >> QW);
                        r_dlow <= dv_num[QW-1:0];
                        r_q    <= '0;
                        r_cnt  <= r_cnt + 1'b1;
                    end else begin
                        // one quotient bit per cycle
                        r_drem <= dv_ge ? 32'(dv_trial - {2'b00, r_root}) : dv_trial[31:0];
                        r_dlow <= r_dlow << 1;
                        r_q    <= n_q;
                        if (div_last) begin
                            r_ax[pax][r_di] <= r_nneg[r_di] ? -AW'(n_q) : AW'(n_q);
                            r_cnt <= '0;
                            if (r_di == 2'd2) begin
                                r_ph     <= r_pass ? PH_CR2 : PH_CR1;
                                r_missue <= 1'b1;
                                r_mj     <= 2'd0;
                                r_mt     <= 2'd0;
                                r_state  <= S_MAC;
                            end else begin
                                r_di <= r_di + 2'd1;
                            end
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    if (i_mat_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a normalized component never exceeds one
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_last |-> (n_q <= Q_ONE))
        else $error("normalized component above one");

    // the accumulate pipe is empty whenever a new job is taken
    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (!r_pv && !r_rv && !r_missue))
        else $error("job taken with products in flight");

endmodule

/* hdl/lav_emit.sv */
// ----------------------------------------------------------------------------
// lav_emit
// Result emitter: holds one finished matrix and sends its four rows on
// consecutive cycles while the back end works on the next job.
// ----------------------------------------------------------------------------
module lav_emit #(
    parameter int FRAC_BITS = lav_pkg::LAV_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mat_valid,
    input  lav_pkg::t_lav_mat   i_mat,
    output logic                o_mat_ready,
    output logic                o_strobe,
    output lav_pkg::t_lav_rsp   o_result
);
    import lav_pkg::*;

    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic     r_busy;
    t_lav_grp r_grp;
    t_lav_mat r_mat;
    logic     load;
    t_lav_rsp n_result;

    assign o_mat_ready = !r_busy || (r_grp == GRP_C);
    assign load        = i_mat_valid && o_mat_ready;

    // row selection
    always_comb begin
        n_result             = '0;
        n_result.group_index = r_grp;
        n_result.degenerate  = r_mat.deg;
        unique case (r_grp)
            GRP_X, GRP_Y, GRP_Z: begin
                n_result.elem0 = r_mat.rows[r_grp][0];
                n_result.elem1 = r_mat.rows[r_grp][1];
                n_result.elem2 = r_mat.rows[r_grp][2];
                n_result.elem3 = r_mat.rows[r_grp][3];
            end
            default: begin
                n_result.elem3      = ONE;
                n_result.last_group = 1'b1;
            end
        endcase
    end

    // sequencing of the four rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_grp    <= GRP_X;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_busy;
            if (load) begin
                r_busy <= 1'b1;
                r_grp  <= GRP_X;
            end else if (r_busy) begin
                if (r_grp == GRP_C) begin
                    r_busy <= 1'b0;
                end else begin
                    r_grp <= t_lav_grp'(r_grp + 2'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mat <= i_mat;
        end
        o_result <= n_result;
    end

    // rows of one matrix leave on back-to-back cycles
    a_rows_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_grp != GRP_C) |=> (o_strobe && r_busy))
        else $error("gap inside a result group sequence");

endmodule

/* hdl/look_at_view_matrix_core.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix_core
// Right-handed look-at view matrix in signed fixed point. Each request gives
// eye, target and up; four result rows follow: x, y, z axes with their
// translation terms, then the constant row.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy rises only when
// the request register and the two-entry job queue are all occupied. Results
// come as four rows on consecutive cycles, each marked by o_strobe, and
// cannot be held off. In the back end each normalization shifts one bit per
// cycle and then uses the shared multiplier and the one-bit-per-cycle square
// root and divider; that back-end sequence sets the sustained interval. A
// request whose eye equals its target skips that computation and yields
// all-zero x, y and z rows. Row emission overlaps the next item's computation.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core #(
    parameter int FRAC_BITS = lav_pkg::LAV_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  lav_pkg::t_lav_req   i_req,
    output logic                o_strobe,
    output lav_pkg::t_lav_rsp   o_result
);
    import lav_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    t_lav_job f_job;
    t_lav_job q_job;
    logic     mat_valid;
    logic     mat_ready;
    t_lav_mat mat;

    // request stage
    lav_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (f_job)
    );

    // job queue
    lav_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // matrix computation
    lav_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .i_mat_ready (mat_ready),
        .o_mat_valid (mat_valid),
        .o_mat       (mat)
    );

    // row output
    lav_emit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mat_valid (mat_valid),
        .i_mat       (mat),
        .o_mat_ready (mat_ready),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

/* tb/look_at_view_matrix_core_tb.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix_core_tb
// Drives eye, target and up requests into the look-at core under random start
// gaps, predicts the four matrix rows of each request in fixed point and
// checks every strobed row field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core_tb;
    import lav_pkg::*;

    localparam int FB = LAV_FRAC_BITS;
    localparam int STALL_LIMIT = 20000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_lav_req i_req = '0;
    logic     o_strobe;
    t_lav_rsp o_result;

    look_at_view_matrix_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // clock
    always #4 i_clk = ~i_clk;

    t_lav_req pending_reqs[$];
    t_lav_rsp expected_rows[$];
    int       gap_pct = 19;
    bit       hold_off = 1'b0;
    int       err_count = 0;
    int       idle_cycles = 0;

    function automatic logic [63:0] mag_of(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // round half away from zero by FB fraction bits
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v);
        logic [63:0] m;
        m = (mag_of(v) + (64'd1 << (FB - 1))) >> FB;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // unit vector of v; flags zero length
    task automatic unit_vec(input logic signed [63:0] v[3],
                            output logic signed [63:0] u[3], inout bit deg);
        logic [63:0] m[3], mx, sum, len, q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag_of(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) u[i] = 0;
            deg = 1'b1;
            return;
        end
        while (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            mx <<= 1;
        end
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FB) + (len >> 1)) / len;
            u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
    endtask

    task automatic cross_prod(input logic signed [63:0] a[3], input logic signed [63:0] b[3],
                              output logic signed [63:0] r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endtask

    function automatic logic signed [31:0] neg_dot(input logic signed [63:0] a[3],
                                                   input logic signed [63:0] e[3]);
        logic signed [63:0] d;
        d = -round_shift(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        return d[31:0];
    endfunction

    // predict the four rows of one request
    task automatic predict_rows(input t_lav_req r);
        logic signed [63:0] eye[3], up[3], dir[3], za[3], xa[3], ya[3], zx[3], c[3];
        t_lav_rsp row;
        bit deg;
        deg = 1'b0;
        eye[0] = 64'(r.eye_x); eye[1] = 64'(r.eye_y); eye[2] = 64'(r.eye_z);
        up[0] = 64'(r.up_x); up[1] = 64'(r.up_y); up[2] = 64'(r.up_z);
        dir[0] = eye[0] - 64'(r.target_x);
        dir[1] = eye[1] - 64'(r.target_y);
        dir[2] = eye[2] - 64'(r.target_z);
        unit_vec(dir, za, deg);
        cross_prod(up, za, zx);
        unit_vec(zx, xa, deg);
        cross_prod(za, xa, c);
        for (int i = 0; i < 3; i++) ya[i] = round_shift(c[i]);
        for (int g = 0; g < 3; g++) begin
            row.group_index = t_lav_grp'(g);
            case (g)
                0: begin
                    row.elem0 = 32'(xa[0]); row.elem1 = 32'(xa[1]); row.elem2 = 32'(xa[2]);
                    row.elem3 = neg_dot(xa, eye);
                end
                1: begin
                    row.elem0 = 32'(ya[0]); row.elem1 = 32'(ya[1]); row.elem2 = 32'(ya[2]);
                    row.elem3 = neg_dot(ya, eye);
                end
                default: begin
                    row.elem0 = 32'(za[0]); row.elem1 = 32'(za[1]); row.elem2 = 32'(za[2]);
                    row.elem3 = neg_dot(za, eye);
                end
            endcase
            row.last_group = 1'b0;
            row.degenerate = deg;
            expected_rows.push_back(row);
        end
        row.group_index = GRP_C;
        row.elem0 = 0; row.elem1 = 0; row.elem2 = 0;
        row.elem3 = 32'sd1 <<< FB;
        row.last_group = 1'b1;
        row.degenerate = deg;
        expected_rows.push_back(row);
    endtask

    // driver: one request per accepted start
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_rows(i_req);
                void'(pending_reqs.pop_front());
            end
            if (!(start && busy)) begin
                if (pending_reqs.size() > (start && !busy ? 0 : 0) && !hold_off
                    && $urandom_range(99) >= gap_pct
                    && pending_reqs.size() > 0) begin
                    start <= 1'b1;
                    i_req <= pending_reqs[0];
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare strobed rows in order
    always @(posedge i_clk) begin
        t_lav_rsp exp_row;
        if (i_rst_n && o_strobe) begin
            if (expected_rows.size() == 0) begin
                $error("row with no pending prediction: %p", o_result);
                err_count++;
            end else begin
                exp_row = expected_rows.pop_front();
                if (o_result.group_index !== exp_row.group_index) begin
                    $error("group_index exp %0d got %0d", exp_row.group_index,
                           o_result.group_index);
                    err_count++;
                end
                if (o_result.elem0 !== exp_row.elem0) begin
                    $error("elem0 exp %0d got %0d", exp_row.elem0, o_result.elem0);
                    err_count++;
                end
                if (o_result.elem1 !== exp_row.elem1) begin
                    $error("elem1 exp %0d got %0d", exp_row.elem1, o_result.elem1);
                    err_count++;
                end
                if (o_result.elem2 !== exp_row.elem2) begin
                    $error("elem2 exp %0d got %0d", exp_row.elem2, o_result.elem2);
                    err_count++;
                end
                if (o_result.elem3 !== exp_row.elem3) begin
                    $error("elem3 exp %0d got %0d", exp_row.elem3, o_result.elem3);
                    err_count++;
                end
                if (o_result.last_group !== exp_row.last_group) begin
                    $error("last_group exp %0d got %0d", exp_row.last_group,
                           o_result.last_group);
                    err_count++;
                end
                if (o_result.degenerate !== exp_row.degenerate) begin
                    $error("degenerate exp %0d got %0d", exp_row.degenerate,
                           o_result.degenerate);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request or row accepted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("look_at_view_matrix_core verification failed");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(8)) - 4) <<< FB;
            3: return $urandom_range(3) - 1;
            4: return 32'($signed($urandom_range(2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_lav_req rand_req();
        t_lav_req r;
        r.eye_x = rand_word(); r.eye_y = rand_word(); r.eye_z = rand_word();
        r.target_x = rand_word(); r.target_y = rand_word(); r.target_z = rand_word();
        r.up_x = rand_word(); r.up_y = rand_word(); r.up_z = rand_word();
        case ($urandom_range(9))
            // eye on target
            0: begin r.target_x = r.eye_x; r.target_y = r.eye_y; r.target_z = r.eye_z; end
            // up along the view direction
            1: begin
                r.up_x = 32'(64'(r.eye_x) - 64'(r.target_x));
                r.up_y = 32'(64'(r.eye_y) - 64'(r.target_y));
                r.up_z = 32'(64'(r.eye_z) - 64'(r.target_z));
            end
            2: begin r.up_x = 0; r.up_y = 0; r.up_z = 0; end
            // ordinary camera with modest coordinates
            3, 4, 5: begin
                r.eye_x = $signed($urandom_range(2000000)) - 1000000;
                r.eye_y = $signed($urandom_range(2000000)) - 1000000;
                r.eye_z = $signed($urandom_range(2000000)) - 1000000;
                r.target_x = $signed($urandom_range(2000000)) - 1000000;
                r.target_y = $signed($urandom_range(2000000)) - 1000000;
                r.target_z = $signed($urandom_range(2000000)) - 1000000;
                r.up_x = 0; r.up_y = 32'sd1 <<< FB; r.up_z = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || start || expected_rows.size() > 0)
            @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        t_lav_req r;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: canonical camera, extremes and degenerate cases
        r = '0; r.eye_z = 32'sd5 <<< FB; r.up_y = 32'sd1 <<< FB;
        pending_reqs.push_back(r);
        r = '0; pending_reqs.push_back(r);
        r = '0; r.eye_x = 32'sd3 <<< FB; r.up_x = 32'sd1 <<< FB;
        pending_reqs.push_back(r);
        r = '0; r.eye_y = 32'sd2 <<< FB; pending_reqs.push_back(r);
        r = '1; r.target_x = 0; pending_reqs.push_back(r);
        for (int k = 0; k < 4; k++) begin
            r.eye_x = k[0] ? 32'h7fff_ffff : 32'h8000_0000;
            r.eye_y = k[1] ? 32'h7fff_ffff : 32'h8000_0000;
            r.eye_z = 32'h7fff_ffff;
            r.target_x = k[0] ? 32'h8000_0000 : 32'h7fff_ffff;
            r.target_y = k[1] ? 32'h8000_0000 : 32'h7fff_ffff;
            r.target_z = 32'h8000_0000;
            r.up_x = k[1] ? 32'h7fff_ffff : 32'h8000_0000;
            r.up_y = 32'h8000_0000;
            r.up_z = k[0] ? 32'h8000_0000 : 32'h7fff_ffff;
            pending_reqs.push_back(r);
        end
        r = '0; r.eye_x = 1; r.up_y = 1; pending_reqs.push_back(r);
        r = '0; r.eye_z = 32'h7fff_ffff; r.target_z = 32'h8000_0000;
        r.up_x = 32'h7fff_ffff; pending_reqs.push_back(r);
        wait_drained();

        // pause for drain, then random phases
        hold_off = 1'b1;
        repeat (5) @(posedge i_clk);
        hold_off = 1'b0;
        for (int phase = 0; phase < 3; phase++) begin
            gap_pct = phase == 0 ? 19 : (phase == 1 ? 75 : 0);
            for (int n = 0; n < 150; n++) pending_reqs.push_back(rand_req());
            wait_drained();
        end
        repeat (400) @(posedge i_clk);
        if (err_count == 0 && expected_rows.size() == 0)
            $display("look_at_view_matrix_core verification clean");
        else
            $display("look_at_view_matrix_core verification failed");
        $finish;
    end
endmodule
